// ===== hdl/sha512_pkg.sv =====
package sha512_pkg;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } push_sel_e;

  typedef struct packed {
    logic      push;
    push_sel_e sel;
    logic      count;
    logic      load;
    logic      round;
    logic      add_hash;
    logic      clear;
    logic [6:0] round_idx;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
  } dp_status_t;

  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
  localparam logic [6:0]  LAST_ROUND = 7'd79;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] round_const(logic [6:0] idx);
    logic [63:0] k;
    unique case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/sha512_dp.sv =====
module sha512_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha512_pkg::dp_cmd_t   cmd_i,
  input  logic [63:0]           message_word_i,
  input  logic [3:0]            valid_bytes_i,
  input  logic                  last_word_i,
  output sha512_pkg::dp_status_t status_o,
  output logic [63:0]           digest_word_o
);
  import sha512_pkg::*;

  logic [63:0] hash_q  [8];
  logic [63:0] work_q  [8];
  logic [63:0] sched_q [16];
  logic [63:0] bit_cnt_q;
  logic [3:0]  fill_q;

  logic [63:0] msg_word;
  logic [63:0] push_data;
  logic [63:0] bit_incr;
  logic [5:0]  byte_shift;
  logic [63:0] t1, t2, new_w;

  function automatic logic [63:0] rotr(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // Keep the leading bytes of a short last word and append the pad bit
  assign byte_shift = {valid_bytes_i[2:0], 3'b000};

  always_comb begin
    if (!last_word_i || valid_bytes_i[3]) begin
      msg_word = message_word_i;
    end else begin
      msg_word = (message_word_i & ~({64{1'b1}} >> byte_shift)) | (PAD_WORD >> byte_shift);
    end
  end

  always_comb begin
    if (!last_word_i || valid_bytes_i[3]) begin
      bit_incr = 64'd64;
    end else begin
      bit_incr = {58'd0, byte_shift};
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_MSG:   push_data = msg_word;
      SEL_PAD80: push_data = PAD_WORD;
      SEL_LEN:   push_data = bit_cnt_q;
      default:   push_data = 64'd0;
    endcase
  end

  // One round: sched_q[0] holds W[t], new_w is W[t+16]
  assign t1 = work_q[7] + bsig1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + round_const(cmd_i.round_idx) + sched_q[0];
  assign t2 = bsig0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
  assign new_w = ssig1(sched_q[14]) + sched_q[9] + ssig0(sched_q[1]) + sched_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= IV[i];
      end
      bit_cnt_q <= 64'd0;
      fill_q    <= 4'd0;
    end else begin
      if (cmd_i.clear) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= IV[i];
        end
        bit_cnt_q <= 64'd0;
        fill_q    <= 4'd0;
      end else begin
        if (cmd_i.add_hash) begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + work_q[i];
          end
        end
        if (cmd_i.count) begin
          bit_cnt_q <= bit_cnt_q + bit_incr;
        end
        // 4-bit fill wraps to zero as the block completes
        if (cmd_i.push) begin
          fill_q <= fill_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      sched_q[fill_q] <= push_data;
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= new_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i] <= hash_q[i];
      end
    end else if (cmd_i.round) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = hash_q[cmd_i.out_idx];

endmodule

// ===== hdl/sha512_ctrl.sv =====
module sha512_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   last_word_i,
  input  logic                   full_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             word_index_o,
  output logic                   last_digest_o,
  output sha512_pkg::dp_cmd_t    cmd_o,
  input  sha512_pkg::dp_status_t status_i
);
  import sha512_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [1:0] PH_MSG  = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [3:0] FILL_LEN_SLOT = 4'd14;
  localparam logic [3:0] FILL_FULL     = 4'd15;
  localparam logic [2:0] IDX_LAST      = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       pend80_q, pend80_d;
  logic       len_next_q, len_next_d;
  logic [6:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    pend80_d   = pend80_q;
    len_next_d = len_next_q;
    round_d    = round_q;
    idx_d      = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o           = '0;
    cmd_o.sel       = SEL_MSG;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push  = 1'b1;
          cmd_o.count = 1'b1;
          if (last_word_i) begin
            phase_d    = PH_PAD;
            pend80_d   = full_word_i;
            len_next_d = 1'b0;
          end
          if (status_i.fill == FILL_FULL) begin
            state_d = ST_LOAD;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        if (pend80_q) begin
          cmd_o.sel = SEL_PAD80;
          pend80_d  = 1'b0;
        end else if (len_next_q) begin
          cmd_o.sel  = SEL_LEN;
          len_next_d = 1'b0;
          phase_d    = PH_DONE;
        end else begin
          cmd_o.sel = SEL_ZERO;
          // the zero in slot 14 is the high length word
          if (status_i.fill == FILL_LEN_SLOT) begin
            len_next_d = 1'b1;
          end
        end
        if (status_i.fill == FILL_FULL) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        round_d    = 7'd0;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        round_d     = round_q + 7'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_hash = 1'b1;
        unique case (phase_q)
          PH_MSG:  state_d = ST_IDLE;
          PH_PAD:  state_d = ST_PAD;
          default: begin
            state_d = ST_OUT;
            idx_d   = 3'd0;
          end
        endcase
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == IDX_LAST) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_MSG;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_MSG;
      pend80_q   <= 1'b0;
      len_next_q <= 1'b0;
      round_q    <= 7'd0;
      idx_q      <= 3'd0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      pend80_q   <= pend80_d;
      len_next_q <= len_next_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
    end
  end

  assign word_index_o  = idx_q;
  assign last_digest_o = (idx_q == IDX_LAST);

endmodule

// ===== hdl/sha512_hash_core.sv =====
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   message_word_i, valid_bytes_i, last_word_i
// out      out_valid_o/out_ready_i digest_word_o, word_index_o, last_digest_o
//
// A word that does not complete a block goes in without a stall. The 16th word
// of a block is followed by load, 80 rounds of the single round unit, hash add.
// After the last word, padding words go in one per cycle, paused by one or two
// block compressions, then eight output beats, one per accepted cycle.
// Reset is asynchronous, active low, and loads the initial hash value.
// Input stalls in padding, compression, output; output stalls hold the digest.
module sha512_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_digest_o
);
  import sha512_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  sha512_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_word_i   (last_word_i),
    .full_word_i   (valid_bytes_i[3]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_index_o  (word_index_o),
    .last_digest_o (last_digest_o),
    .cmd_o         (dp_cmd),
    .status_i      (dp_status)
  );

  sha512_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .status_o       (dp_status),
    .digest_word_o  (digest_word_o)
  );

`ifndef ASSERT_OFF
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while digest is shown");

  a_fill_empty_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dp_status.fill == 4'd0))
    else $error("block buffer not empty at digest output");

  a_last_starts_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_word_i) |=> (!in_ready_o && !out_valid_o))
    else $error("last word did not start padding");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_digest_o) |=> in_ready_o)
    else $error("core not ready after final digest beat");
`endif

endmodule

// ===== bench/sha512_checker.sv =====
module sha512_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_digest_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic [63:0]  digest_state [8];
  logic [63:0]  block_buf [16];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_expect_q [$];

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    logic [63:0] sched [16];
    logic [63:0] v [8];
    logic [63:0] t1, t2, w2, w15;
    sched = block_buf;
    v = digest_state;
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w2  = sched[(t - 2) % 16];
        w15 = sched[(t - 15) % 16];
        sched[t % 16] = (rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6)) + sched[(t - 7) % 16]
                      + (rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7)) + sched[t % 16];
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t % 16];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) digest_state[i] = digest_state[i] + v[i];
  endtask

  task automatic absorb_word(input logic [63:0] w);
    block_buf[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  task automatic restart_message();
    digest_state = INIT_HASH;
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Pad the tail, run the last block(s) and queue the eight digest beats.
  task automatic finish_message(input logic [63:0] w, input logic [3:0] vb);
    int unsigned nbytes;
    digest_beat_t beat;
    nbytes = (vb > 8) ? 8 : vb;
    msg_bits = msg_bits + 64'(8 * nbytes);
    if (nbytes == 8) begin
      absorb_word(w);
      absorb_word(PAD_MARK);
    end else if (nbytes == 0) begin
      absorb_word(PAD_MARK);
    end else begin
      absorb_word((w & (~64'h0 << (64 - 8 * nbytes))) | (64'h80 << (56 - 8 * nbytes)));
    end
    while (block_fill != 14) absorb_word('0);
    absorb_word('0);
    absorb_word(msg_bits);
    for (int i = 0; i < 8; i++) begin
      beat.word = digest_state[i];
      beat.idx  = 3'(i);
      beat.last = (i == 7);
      digest_expect_q.push_back(beat);
    end
    restart_message();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t exp_beat;
    if (!rst_ni) begin
      restart_message();
      digest_expect_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (last_word_i) begin
          finish_message(message_word_i, valid_bytes_i);
        end else begin
          msg_bits = msg_bits + 64'd64;
          absorb_word(message_word_i);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (digest_expect_q.size() == 0) begin
          $display("%0t: unexpected digest beat: word %h index %0d last %0b", $time,
                   digest_word_i, word_index_i, last_digest_i);
          fail_count_o++;
        end else begin
          exp_beat = digest_expect_q.pop_front();
          if (digest_word_i !== exp_beat.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, exp_beat.word,
                     digest_word_i);
            fail_count_o++;
          end
          if (word_index_i !== exp_beat.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, exp_beat.idx,
                     word_index_i);
            fail_count_o++;
          end
          if (last_digest_i !== exp_beat.last) begin
            $display("%0t: last_digest expected %0b actual %0b", $time, exp_beat.last,
                     last_digest_i);
            fail_count_o++;
          end
        end
      end
      pending_o = digest_expect_q.size();
    end
  end

endmodule

// ===== bench/tb_sha512_hash_core.sv =====
module tb_sha512_hash_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TARGET_WORDS = 460;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] message_word_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_digest_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int words_sent = 0;
  int msgs_sent = 0;
  int boundary_msgs = 0;
  bit calm_msg = 1'b0;

  sha512_hash_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_digest_o  (last_digest_o)
  );

  sha512_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_i  (digest_word_o),
    .word_index_i   (word_index_o),
    .last_digest_i  (last_digest_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall and ready stretches, with some long open windows.
  initial begin
    int pick;
    int run;
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        out_ready_i <= 1'b1;
        run = $urandom_range(200, 40);
      end else if (pick < 55) begin
        out_ready_i <= 1'b1;
        run = $urandom_range(8, 1);
      end else if (pick < 92) begin
        out_ready_i <= 1'b0;
        run = $urandom_range(3, 1);
      end else begin
        out_ready_i <= 1'b0;
        run = $urandom_range(60, 15);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(99);
    if (calm_msg || pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Present one beat, hold it until accepted, then maybe idle.
  task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic last);
    int gap;
    in_valid_i     <= 1'b1;
    message_word_i <= w;
    valid_bytes_i  <= vb;
    last_word_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (last) msgs_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Body words are mostly full; a few carry a junk byte count that must be ignored.
  task automatic send_message(input int body_words);
    logic [3:0] vb;
    calm_msg = ($urandom_range(4) == 0);
    for (int i = 0; i < body_words; i++) begin
      vb = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd8;
      send_word(rand_word(), vb, 1'b0);
    end
    vb = ($urandom_range(6) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    send_word(rand_word(), vb, 1'b1);
  endtask

  initial begin
    int pick;
    int body;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, short tail with junk past the count, full tail both ways.
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'h616263_a5a5a5a5a5, 4'd3, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    // Short body word counts as full; oversized tail count clamps to eight.
    send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
    send_word(64'hfedc_ba98_7654_3210, 4'd9, 1'b1);
    // 111 bytes: the longest message that still fits a single block.
    for (int i = 0; i < 13; i++) send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), 4'd7, 1'b1);

    while (words_sent < TARGET_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        body = $urandom_range(6);
      end else if (pick < 95) begin
        body = $urandom_range(16, 12);
        boundary_msgs++;
      end else begin
        body = $urandom_range(40, 17);
      end
      send_message(body);
    end
    in_valid_i <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d messages in %0d words, %0d of them near the block boundary",
             msgs_sent, words_sent, boundary_msgs);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sha512_pkg.sv
hdl/sha512_dp.sv
hdl/sha512_ctrl.sv
hdl/sha512_hash_core.sv
bench/sha512_checker.sv
bench/tb_sha512_hash_core.sv
